// File: sv/crc8ldc_pkg.sv
`default_nettype none

package crc8ldc_pkg;

  localparam int unsigned PAYLOAD_W = 9;
  localparam int unsigned NUM_PFX = 4;
  localparam int unsigned PFX_MAX = 16;

  localparam logic [7:0] BYTE_CR = 8'd13;
  localparam logic [7:0] BYTE_LF = 8'd10;
  localparam logic [7:0] BYTE_STAR = 8'h2a;
  localparam logic [7:0] CRC_POLY = 8'h8c;

  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_BAD_PREFIX  = 3'd1,
    ST_CRC_MISSING = 3'd2,
    ST_MALFORMED   = 3'd3,
    ST_MISMATCH    = 3'd4
  } line_status_t;

  // prefix 0 "$BS", 1 "$BS RESET", 2 "$BS REBOOT", 3 "$BS CRC_DISABLE"
  localparam logic [3:0] PFX_LEN [NUM_PFX] = '{4'd3, 4'd9, 4'd10, 4'd15};

  localparam logic [7:0] PFX_TEXT [NUM_PFX][PFX_MAX] = '{
    '{"$", "B", "S", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
      8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"$", "B", "S", " ", "R", "E", "S", "E",
      "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"$", "B", "S", " ", "R", "E", "B", "O",
      "O", "T", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"$", "B", "S", " ", "C", "R", "C", "_",
      "D", "I", "S", "A", "B", "L", "E", 8'h00}
  };

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_digit_t;

  // Maxim CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.ok = 1'b1;
    d.value = 4'd0;
    if (b >= 8'd48 && b <= 8'd57) begin
      d.value = 4'(b - 8'd48);
    end else if (b >= 8'd65 && b <= 8'd70) begin
      d.value = 4'(b - 8'd55);
    end else if (b >= 8'd97 && b <= 8'd102) begin
      d.value = 4'(b - 8'd87);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

`default_nettype wire

// File: sv/crc8_line_deframer_checker.sv
// Channel | Signals                          | Direction | Beat
// input   | in_valid/in_ready, data_byte     | in        | one received byte
// output  | out_valid/out_ready, line fields | out       | one checked line
// config  | cfg_wr_en, cfg_wr_data           | in        | crc_required write
//
// One byte per cycle while no result is held: input register, then CRC step, prefix and suffix
// tracking in one stage that loads the line state and the result register.
// An accepted LF beat reaches result valid through the input register and then the result register.
// Synchronous active-high rst clears line state, crc_required and valids.
// A held result stalls the input register and line state; in_ready drops when input register and result are both full.
`default_nettype none

module crc8_line_deframer_checker #(
  parameter int unsigned MAX_LINE = 511
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [2:0]      line_status,
  output logic [8:0]      payload_length,
  output logic [7:0]      crc_computed,
  output logic            crc_exempt,
  output logic            crc_present,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data
);

  localparam int unsigned LEN_W = $clog2(MAX_LINE + 1);
  localparam int unsigned PLW = crc8ldc_pkg::PAYLOAD_W;
  localparam int unsigned NP = crc8ldc_pkg::NUM_PFX;

  logic             crc_required;

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic             s1_go;

  logic [7:0]       running_crc, running_crc_next;
  logic [7:0]       crc_at_star, crc_at_star_next;
  logic [LEN_W-1:0] star_position, star_position_next;
  logic             star_seen, star_seen_next;
  logic [1:0]       chars_after_star, chars_after_star_next;
  logic [7:0]       suffix_hex_value, suffix_hex_value_next;
  logic             suffix_hex_ok, suffix_hex_ok_next;
  logic [LEN_W-1:0] line_length, line_length_next;
  logic [NP-1:0]    prefix_match_flags, prefix_match_flags_next;

  logic                     emit;
  logic [NP-1:0]            matched;
  logic                     exempt;
  logic [LEN_W-1:0]         payload;
  logic [LEN_W+PLW-1:0]     payload_wide;
  logic [7:0]               crc_sel;
  crc8ldc_pkg::line_status_t status;
  crc8ldc_pkg::hex_digit_t  hd;

  assign s1_go = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_required <= 1'b0;
    end else if (cfg_wr_en) begin
      crc_required <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
    end
  end

  always_comb begin
    for (int k = 0; k < NP; k++) begin
      matched[k] = prefix_match_flags[k] &&
                   (line_length >= LEN_W'(crc8ldc_pkg::PFX_LEN[k]));
    end
    exempt = |matched[NP-1:1];
    payload = star_seen ? star_position : line_length;
    payload_wide = (LEN_W+PLW)'(payload);
    crc_sel = star_seen ? crc_at_star : running_crc;
    if (!matched[0]) begin
      status = crc8ldc_pkg::ST_BAD_PREFIX;
    end else if (!star_seen) begin
      status = (crc_required && !exempt) ? crc8ldc_pkg::ST_CRC_MISSING
                                         : crc8ldc_pkg::ST_ACCEPTED;
    end else if (chars_after_star != 2'd2 || !suffix_hex_ok) begin
      status = crc8ldc_pkg::ST_MALFORMED;
    end else if (crc_sel != suffix_hex_value) begin
      status = crc8ldc_pkg::ST_MISMATCH;
    end else begin
      status = crc8ldc_pkg::ST_ACCEPTED;
    end
  end

  always_comb begin
    hd = crc8ldc_pkg::hex_decode(s1_byte);
    emit = 1'b0;
    running_crc_next = running_crc;
    crc_at_star_next = crc_at_star;
    star_position_next = star_position;
    star_seen_next = star_seen;
    chars_after_star_next = chars_after_star;
    suffix_hex_value_next = suffix_hex_value;
    suffix_hex_ok_next = suffix_hex_ok;
    line_length_next = line_length;
    prefix_match_flags_next = prefix_match_flags;

    if (s1_byte == crc8ldc_pkg::BYTE_CR) begin
      // skipped
    end else if (s1_byte == crc8ldc_pkg::BYTE_LF ||
                 line_length >= LEN_W'(MAX_LINE)) begin
      emit = (s1_byte == crc8ldc_pkg::BYTE_LF) && (line_length != '0);
      running_crc_next = '0;
      crc_at_star_next = '0;
      star_position_next = '0;
      star_seen_next = 1'b0;
      chars_after_star_next = '0;
      suffix_hex_value_next = '0;
      suffix_hex_ok_next = 1'b1;
      line_length_next = '0;
      prefix_match_flags_next = '1;
    end else begin
      for (int k = 0; k < NP; k++) begin
        if (line_length < LEN_W'(crc8ldc_pkg::PFX_LEN[k]) &&
            s1_byte != crc8ldc_pkg::PFX_TEXT[k][line_length[3:0]]) begin
          prefix_match_flags_next[k] = 1'b0;
        end
      end
      if (s1_byte == crc8ldc_pkg::BYTE_STAR) begin
        crc_at_star_next = running_crc;
        star_position_next = line_length;
        star_seen_next = 1'b1;
        chars_after_star_next = '0;
        suffix_hex_value_next = '0;
        suffix_hex_ok_next = 1'b1;
      end else if (star_seen) begin
        if (chars_after_star < 2'd2) begin
          if (!hd.ok) begin
            suffix_hex_ok_next = 1'b0;
          end else begin
            suffix_hex_value_next = {suffix_hex_value[3:0], hd.value};
          end
        end
        if (chars_after_star != 2'd3) begin
          chars_after_star_next = chars_after_star + 2'd1;
        end
      end
      running_crc_next = crc8ldc_pkg::crc8_step(running_crc, s1_byte);
      line_length_next = line_length + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      crc_at_star <= '0;
      star_position <= '0;
      star_seen <= 1'b0;
      chars_after_star <= '0;
      suffix_hex_value <= '0;
      suffix_hex_ok <= 1'b1;
      line_length <= '0;
      prefix_match_flags <= '1;
    end else if (s1_go) begin
      running_crc <= running_crc_next;
      crc_at_star <= crc_at_star_next;
      star_position <= star_position_next;
      star_seen <= star_seen_next;
      chars_after_star <= chars_after_star_next;
      suffix_hex_value <= suffix_hex_value_next;
      suffix_hex_ok <= suffix_hex_ok_next;
      line_length <= line_length_next;
      prefix_match_flags <= prefix_match_flags_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_go && emit) begin
      line_status <= status;
      payload_length <= payload_wide[PLW-1:0];
      crc_computed <= crc_sel;
      crc_exempt <= exempt;
      crc_present <= star_seen;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    line_length <= LEN_W'(MAX_LINE))
    else $error("line length past limit");

  a_star_pos: assert property (@(posedge clk) disable iff (rst)
    star_seen |-> star_position < line_length)
    else $error("star position not inside line");

  a_emit_on_lf: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_byte) == crc8ldc_pkg::BYTE_LF)
    else $error("result without line end");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> line_status <= crc8ldc_pkg::ST_MISMATCH)
    else $error("status code out of range");

endmodule

`default_nettype wire

// File: dv/crc8_line_deframer_checker_test.sv
`default_nettype none

module crc8_line_deframer_checker_test;

  localparam int unsigned LINE_CAP = 511;
  localparam int unsigned PHASE_BEATS = 67;
  localparam int unsigned NUM_PHASES = 6;
  localparam int unsigned STALL_LIMIT = 300;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct packed {
    crc8ldc_pkg::line_status_t status;
    logic [8:0]   plen;
    logic [7:0]   crc;
    logic         exempt;
    logic         present;
  } line_result_t;

  typedef logic [7:0] beat_q_t[$];

  typedef struct {
    string        text;
    bit           req;
    bit           typed;
    crc8ldc_pkg::line_status_t st;
    int unsigned  plen;
    bit           ex;
    bit           pr;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] line_status;
  logic [8:0] payload_length;
  logic [7:0] crc_computed;
  logic       crc_exempt;
  logic       crc_present;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;

  crc8_line_deframer_checker #(
    .MAX_LINE(LINE_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .line_status(line_status),
    .payload_length(payload_length),
    .crc_computed(crc_computed),
    .crc_exempt(crc_exempt),
    .crc_present(crc_present),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // line tracking state
  logic [7:0]  run_crc;
  logic [7:0]  star_crc;
  logic [8:0]  star_pos;
  logic        have_star;
  logic [1:0]  sfx_cnt;
  logic [7:0]  sfx_val;
  logic        sfx_good;
  int unsigned line_len;
  logic [3:0]  pfx_alive;
  logic        need_crc = 1'b0;

  string cmd_pfx [4] = '{"$BS", "$BS RESET", "$BS REBOOT", "$BS CRC_DISABLE"};

  line_result_t exp_lines[$];
  int unsigned  beats_fed = 0;
  int unsigned  lines_checked = 0;
  int unsigned  rule_writes = 0;
  int unsigned  errors = 0;
  int unsigned  seen_status [8];
  int unsigned  stall_cnt = 0;
  bit           steady = 1'b0;
  bit           line_closed;

  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = {1'b0, c[7:1]} ^ (c[0] ? crc8ldc_pkg::CRC_POLY : 8'h00);
    return c;
  endfunction

  function automatic int hex_val(input logic [7:0] b);
    if (b >= 8'd48 && b <= 8'd57) return int'(b) - 48;
    if (b >= 8'd65 && b <= 8'd70) return int'(b) - 55;
    if (b >= 8'd97 && b <= 8'd102) return int'(b) - 87;
    return -1;
  endfunction

  function automatic void clear_line();
    run_crc = 8'h00;
    star_crc = 8'h00;
    star_pos = 9'd0;
    have_star = 1'b0;
    sfx_cnt = 2'd0;
    sfx_val = 8'h00;
    sfx_good = 1'b1;
    line_len = 0;
    pfx_alive = 4'hf;
  endfunction

  // advances the line state by one beat; returns 1 when a line result is due
  function automatic bit predict_beat(input logic [7:0] b, output line_result_t r);
    logic [3:0] hit;
    logic       ex;
    int         d;
    int         k;
    r = '0;
    if (b == crc8ldc_pkg::BYTE_CR) return 1'b0;
    if (b == crc8ldc_pkg::BYTE_LF) begin
      if (line_len == 0) return 1'b0;
      hit = 4'h0;
      for (k = 0; k < 4; k++) begin
        if (pfx_alive[k] && line_len >= cmd_pfx[k].len()) hit[k] = 1'b1;
      end
      ex = |hit[3:1];
      r.plen = have_star ? star_pos : 9'(line_len);
      r.crc = have_star ? star_crc : run_crc;
      r.exempt = ex;
      r.present = have_star;
      if (!hit[0]) r.status = crc8ldc_pkg::ST_BAD_PREFIX;
      else if (!have_star)
        r.status = (need_crc && !ex) ? crc8ldc_pkg::ST_CRC_MISSING : crc8ldc_pkg::ST_ACCEPTED;
      else if (sfx_cnt != 2'd2 || !sfx_good) r.status = crc8ldc_pkg::ST_MALFORMED;
      else if (r.crc != sfx_val) r.status = crc8ldc_pkg::ST_MISMATCH;
      else r.status = crc8ldc_pkg::ST_ACCEPTED;
      clear_line();
      return 1'b1;
    end
    if (line_len >= LINE_CAP) begin
      clear_line();
      return 1'b0;
    end
    for (k = 0; k < 4; k++) begin
      if (line_len < cmd_pfx[k].len() && b != cmd_pfx[k][line_len]) pfx_alive[k] = 1'b0;
    end
    if (b == crc8ldc_pkg::BYTE_STAR) begin
      star_crc = run_crc;
      star_pos = 9'(line_len);
      have_star = 1'b1;
      sfx_cnt = 2'd0;
      sfx_val = 8'h00;
      sfx_good = 1'b1;
    end else if (have_star) begin
      if (sfx_cnt < 2'd2) begin
        d = hex_val(b);
        if (d < 0) sfx_good = 1'b0;
        else sfx_val = {sfx_val[3:0], 4'(d)};
      end
      if (sfx_cnt != 2'd3) sfx_cnt++;
    end
    run_crc = crc8_fold(run_crc, b);
    line_len++;
    return 1'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'd48 + 8'(nib);
    return ($urandom_range(0, 1) ? 8'd65 : 8'd97) + 8'(nib) - 8'd10;
  endfunction

  function automatic logic [7:0] plain_char();
    logic [7:0] v;
    do v = 8'($urandom_range(32, 126)); while (v == crc8ldc_pkg::BYTE_STAR);
    return v;
  endfunction

  function automatic beat_q_t random_line();
    beat_q_t     ln;
    logic [7:0]  crc;
    logic [7:0]  v;
    int unsigned pick;
    int unsigned form;
    int unsigned n;
    string       head;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      // command-shaped line, sometimes with a corrupted prefix
      head = cmd_pfx[$urandom_range(0, 3)];
      for (int i = 0; i < head.len(); i++) ln.push_back(head[i]);
      if (pick >= 60) ln[$urandom_range(0, ln.size() - 1)] = plain_char();
      n = $urandom_range(0, 8);
      repeat (n) ln.push_back(plain_char());
      if ($urandom_range(0, 9) == 0) begin
        ln.push_back(crc8ldc_pkg::BYTE_STAR);
        ln.push_back(plain_char());
      end
      form = $urandom_range(0, 99);
      if (form < 75 || form >= 85) begin
        crc = 8'h00;
        foreach (ln[i]) crc = crc8_fold(crc, ln[i]);
        if (form < 60) v = crc;
        else if (form < 75) v = crc ^ 8'($urandom_range(1, 255));
        else v = 8'($urandom_range(0, 255));
        ln.push_back(crc8ldc_pkg::BYTE_STAR);
        if (form < 90) begin
          ln.push_back(hex_char(v[7:4]));
          if (form < 85) ln.push_back(hex_char(v[3:0]));
        end else begin
          ln.push_back(hex_char(v[7:4]));
          ln.push_back(hex_char(v[3:0]));
          if (form < 95) ln.push_back(hex_char(4'($urandom_range(0, 15))));
          else ln[ln.size() - 1 - $urandom_range(0, 1)] = 8'($urandom_range(103, 122));
        end
      end
    end else if (pick < 85) begin
      n = $urandom_range(1, 12);
      repeat (n) begin
        do v = 8'($urandom_range(0, 255)); while (v == crc8ldc_pkg::BYTE_LF);
        ln.push_back(v);
      end
    end else if (pick < 90) begin
      if ($urandom_range(0, 1)) ln.push_back(crc8ldc_pkg::BYTE_CR);
    end else begin
      n = $urandom_range(1, 14);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) ln.push_back(crc8ldc_pkg::BYTE_STAR);
        else if ($urandom_range(0, 1)) ln.push_back(hex_char(4'($urandom_range(0, 15))));
        else ln.push_back(plain_char());
      end
    end
    if ($urandom_range(0, 9) == 0) ln.insert($urandom_range(0, ln.size()), crc8ldc_pkg::BYTE_CR);
    ln.push_back(crc8ldc_pkg::BYTE_LF);
    return ln;
  endfunction

  // full-length line; with spill the next beat overflows and a new line follows
  function automatic beat_q_t long_line(input bit spill);
    beat_q_t ln;
    string   tail;
    tail = "$BS RESET";
    for (int i = 0; i < 3; i++) ln.push_back(tail[i]);
    while (ln.size() < LINE_CAP) ln.push_back(plain_char());
    if (spill) begin
      ln.push_back(plain_char());
      for (int i = 0; i < tail.len(); i++) ln.push_back(tail[i]);
    end
    ln.push_back(crc8ldc_pkg::BYTE_LF);
    return ln;
  endfunction

  task automatic feed_byte(input logic [7:0] b);
    int unsigned  gap;
    line_result_t r;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    beats_fed++;
    line_closed = predict_beat(b, r);
    if (line_closed) exp_lines.push_back(r);
  endtask

  task automatic set_checksum_rule(input bit v);
    in_valid <= 1'b0;
    while (exp_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    need_crc = v;
    rule_writes++;
  endtask

  task automatic check_line();
    line_result_t want;
    if (exp_lines.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected line result: status %0d len %0d crc %02h exempt %0b present %0b",
                 line_status, payload_length, crc_computed, crc_exempt, crc_present);
      return;
    end
    want = exp_lines.pop_front();
    lines_checked++;
    seen_status[line_status]++;
    if (line_status != want.status || payload_length != want.plen ||
        crc_computed != want.crc || crc_exempt != want.exempt ||
        crc_present != want.present) begin
      errors++;
      if (errors <= 10)
        $display("line %0d: expected status %0d len %0d crc %02h exempt %0b present %0b, %s",
                 lines_checked, want.status, want.plen, want.crc, want.exempt, want.present,
                 $sformatf("got status %0d len %0d crc %02h exempt %0b present %0b",
                           line_status, payload_length, crc_computed, crc_exempt,
                           crc_present));
    end
  endtask

  // result side
  initial begin
    int unsigned gap;
    while (rst) @(posedge clk);
    forever begin
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_line();
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
      if (stall_cnt == STALL_LIMIT) begin
        $display("no beat moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t     dir_rows[$];
    beat_q_t      ln;
    line_result_t fix;
    logic [7:0]   c;
    int unsigned  phase_start;

    // \001 in a row stands for a NUL beat
    dir_rows = '{
      '{"$BS\n",              1'b0, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    3,  1'b0, 1'b0},
      '{"\n",                 1'b0, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0},
      '{"\r$BS\r\n",          1'b0, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    3,  1'b0, 1'b0},
      '{"XBS\n",              1'b0, 1'b1, crc8ldc_pkg::ST_BAD_PREFIX,  3,  1'b0, 1'b0},
      '{"$B\n",               1'b0, 1'b1, crc8ldc_pkg::ST_BAD_PREFIX,  2,  1'b0, 1'b0},
      '{"AB*zz\n",            1'b0, 1'b1, crc8ldc_pkg::ST_BAD_PREFIX,  2,  1'b0, 1'b1},
      '{"$BS\001\377\n",      1'b0, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    5,  1'b0, 1'b0},
      '{"$BS*\n",             1'b0, 1'b1, crc8ldc_pkg::ST_MALFORMED,   3,  1'b0, 1'b1},
      '{"$BS*3\n",            1'b0, 1'b1, crc8ldc_pkg::ST_MALFORMED,   3,  1'b0, 1'b1},
      '{"$BS*3g\n",           1'b0, 1'b1, crc8ldc_pkg::ST_MALFORMED,   3,  1'b0, 1'b1},
      '{"$BS*391\n",          1'b0, 1'b1, crc8ldc_pkg::ST_MALFORMED,   3,  1'b0, 1'b1},
      '{"$BS*39\n",           1'b0, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0},
      '{"$BS*3A\n",           1'b0, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0},
      '{"$BS*x*39\n",         1'b0, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0},
      '{"\r\r\n",             1'b0, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0},
      '{"$BS\n",              1'b1, 1'b1, crc8ldc_pkg::ST_CRC_MISSING, 3,  1'b0, 1'b0},
      '{"$BS RESET\n",        1'b1, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    9,  1'b1, 1'b0},
      '{"$BS REBOOT now\n",   1'b1, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    14, 1'b1, 1'b0},
      '{"$BS CRC_DISABLE\n",  1'b1, 1'b1, crc8ldc_pkg::ST_ACCEPTED,    15, 1'b1, 1'b0},
      '{"$BS RESE\n",         1'b1, 1'b1, crc8ldc_pkg::ST_CRC_MISSING, 8,  1'b0, 1'b0},
      '{"$BS CRC_DISARMS\n",  1'b1, 1'b1, crc8ldc_pkg::ST_CRC_MISSING, 15, 1'b0, 1'b0},
      '{"$BS REBOOT*5Z\n",    1'b1, 1'b1, crc8ldc_pkg::ST_MALFORMED,   10, 1'b1, 1'b1},
      '{"$BS*39\n",           1'b1, 1'b0, crc8ldc_pkg::ST_ACCEPTED,    0,  1'b0, 1'b0}
    };

    clear_line();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (i == 0 || dir_rows[i].req != dir_rows[i - 1].req) set_checksum_rule(dir_rows[i].req);
      for (int k = 0; k < dir_rows[i].text.len(); k++) begin
        c = dir_rows[i].text[k];
        feed_byte((c == 8'h01) ? 8'h00 : c);
      end
      if (dir_rows[i].typed && line_closed) begin
        fix = exp_lines.pop_back();
        fix.status = dir_rows[i].st;
        fix.plen = 9'(dir_rows[i].plen);
        fix.exempt = dir_rows[i].ex;
        fix.present = dir_rows[i].pr;
        exp_lines.push_back(fix);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_checksum_rule(p[0]);
      phase_start = beats_fed;
      while (beats_fed < phase_start + PHASE_BEATS) begin
        steady = ($urandom_range(0, 4) == 0);
        ln = random_line();
        foreach (ln[i]) feed_byte(ln[i]);
      end
      if (p == 1 || p == 4) begin
        ln = long_line(p == 4);
        foreach (ln[i]) feed_byte(ln[i]);
      end
    end

    steady = 1'b0;
    in_valid <= 1'b0;
    while (exp_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d byte beats fed, %0d lines checked, crc_required written %0d times",
             beats_fed, lines_checked, rule_writes);
    $display("by status: accepted %0d, bad prefix %0d, missing %0d, malformed %0d, mismatch %0d",
             seen_status[crc8ldc_pkg::ST_ACCEPTED], seen_status[crc8ldc_pkg::ST_BAD_PREFIX],
             seen_status[crc8ldc_pkg::ST_CRC_MISSING], seen_status[crc8ldc_pkg::ST_MALFORMED],
             seen_status[crc8ldc_pkg::ST_MISMATCH]);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
